### src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define SCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under active-low reset
`define SCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/scr_pkg.sv
// types, constants and arithmetic helpers of the corridor rectangle unit
package scr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;
    localparam int DELTA_W     = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * DELTA_W;
    localparam int NORM_W      = 62;
    localparam int ROOT_W      = 31;
    localparam int ROOT_STEPS  = 31;
    localparam int REM_W       = ROOT_W + 2;
    localparam int MAG_W       = 32;
    localparam int UNIT_FRAC   = 14;
    localparam int UNIT_ONE    = 1 << UNIT_FRAC;
    localparam int UNIT_W      = 16;
    localparam int QUO_W       = 16;
    localparam int DIVN_W      = ROOT_W + 1 + QUO_W - 1;
    localparam int PROD_W      = 32;
    localparam int OFF_W       = PROD_W + 2;
    localparam int PROD_FRAC   = 22;
    localparam int RSH         = PROD_FRAC - FRAC_BITS;
    localparam int SUM_W       = OFF_W + 1;
    localparam int RO_W        = SUM_W - RSH;
    localparam int PLACE_W     = 40;
    localparam int CFG_W       = 16;
    localparam int MAP_W       = 15;
    localparam int HALF_SHIFT  = 9;
    localparam int HW_W        = CFG_W + FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CORRIDOR_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_LEN        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 8'd3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DELTA_W-1:0]     t_delta;
    typedef logic signed [RO_W-1:0]        t_ro;

    typedef struct packed {
        t_coord p1x;
        t_coord p1y;
        t_coord p2x;
        t_coord p2y;
        t_delta dx;
        t_delta dy;
        logic   degen;
    } t_seg;

    typedef struct packed {
        logic [CFG_W-1:0] corridor_width;
        logic [CFG_W-1:0] ext_len;
        logic [MAP_W-1:0] map_width;
        logic [MAP_W-1:0] map_height;
    } t_cfg;

    typedef struct packed {
        t_coord c1x;
        t_coord c1y;
        t_coord c2x;
        t_coord c2y;
        t_coord c3x;
        t_coord c3y;
        t_coord c4x;
        t_coord c4y;
        logic   degen;
    } t_rect;

    function automatic t_coord sat_coord(input logic signed [PLACE_W-1:0] v);
        logic signed [PLACE_W-1:0] hi;
        logic signed [PLACE_W-1:0] lo;
        hi = '0;
        hi[COORD_WIDTH-1:0] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        lo = -hi - PLACE_W'(1);
        if (v > hi) begin
            sat_coord = COORD_WIDTH'(hi);
        end else if (v < lo) begin
            sat_coord = COORD_WIDTH'(lo);
        end else begin
            sat_coord = COORD_WIDTH'(v);
        end
    endfunction

    // q.22 offset rounded to the coordinate lsb
    function automatic t_ro round_off(input logic signed [OFF_W-1:0] off);
        logic signed [SUM_W-1:0] bias;
        logic signed [SUM_W-1:0] sum;
        bias = '0;
        bias[RSH-1] = 1'b1;
        sum = SUM_W'(off) + bias;
        round_off = RO_W'(sum >>> RSH);
    endfunction

    function automatic t_coord place(input t_coord p, input t_ro ro,
                                     input logic [MAP_W-1:0] size);
        logic [MAP_W-1:0]          sz1;
        logic signed [PLACE_W-1:0] hi;
        logic signed [PLACE_W-1:0] v;
        sz1 = (size == '0) ? '0 : size - MAP_W'(1);
        hi = $signed({{(PLACE_W-MAP_W){1'b0}}, sz1}) <<< FRAC_BITS;
        v = PLACE_W'(p) + PLACE_W'(ro);
        if (v < 0) begin
            v = '0;
        end
        if (v > hi) begin
            v = hi;
        end
        place = sat_coord(v);
    endfunction

endpackage

### src/scr_if.sv
// handshake channels of the corridor rectangle unit
interface scr_pt_if;
    import scr_pkg::*;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   path_start;
    modport source(output valid, point_x, point_y, path_start, input ready);
    modport sink(input valid, point_x, point_y, path_start, output ready);
endinterface

interface scr_rect_if;
    import scr_pkg::*;
    logic   valid;
    logic   ready;
    t_coord corner1_x;
    t_coord corner1_y;
    t_coord corner2_x;
    t_coord corner2_y;
    t_coord corner3_x;
    t_coord corner3_y;
    t_coord corner4_x;
    t_coord corner4_y;
    logic   degenerate;
    modport source(output valid, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x,
                   corner3_y, corner4_x, corner4_y, degenerate, input ready);
    modport sink(input valid, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x,
                 corner3_y, corner4_x, corner4_y, degenerate, output ready);
endinterface

interface scr_cfg_if;
    import scr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### src/scr_front.sv
// front end: keeps the previous point and turns point pairs into segments
module scr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  scr_pkg::t_coord  i_point_x,
    input  scr_pkg::t_coord  i_point_y,
    input  logic             i_path_start,
    output logic             o_push,
    output scr_pkg::t_seg    o_seg,
    input  logic             i_push_ready
);
    import scr_pkg::*;

    logic   r_have_prev;
    t_coord r_prev_x;
    t_coord r_prev_y;
    logic   w_acc;
    t_delta w_dx;
    t_delta w_dy;

    assign o_ready = i_push_ready;
    assign w_acc   = i_valid && i_push_ready;
    assign w_dx    = DELTA_W'(i_point_x) - DELTA_W'(r_prev_x);
    assign w_dy    = DELTA_W'(i_point_y) - DELTA_W'(r_prev_y);
    // a point with no stored predecessor only opens a path
    assign o_push  = w_acc && !i_path_start && r_have_prev;

    always_comb begin
        o_seg.p1x   = r_prev_x;
        o_seg.p1y   = r_prev_y;
        o_seg.p2x   = i_point_x;
        o_seg.p2y   = i_point_y;
        o_seg.dx    = w_dx;
        o_seg.dy    = w_dy;
        o_seg.degen = (w_dx == '0) && (w_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else if (w_acc) begin
            r_have_prev <= 1'b1;
            r_prev_x    <= i_point_x;
            r_prev_y    <= i_point_y;
        end
    end

endmodule

### src/scr_queue.sv
// two-entry segment queue between front and back
module scr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scr_pkg::t_seg i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output scr_pkg::t_seg o_pop_data,
    input  logic          i_pop_ready
);
    import scr_pkg::*;

    t_seg       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_wr_en;
    logic       w_rd_en;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_wr_en      = i_push && o_push_ready;
    assign w_rd_en      = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr_en) begin
                r_wr <= !r_wr;
            end
            if (w_rd_en) begin
                r_rd <= !r_rd;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### src/scr_back.sv
// back end: sequencer for length, unit vector, offsets and clamped corners, or a square for a zero-length segment
module scr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scr_pkg::t_cfg i_cfg,
    input  logic          i_pop_valid,
    input  scr_pkg::t_seg i_pop_data,
    output logic          o_pop_ready,
    output logic          o_valid,
    output scr_pkg::t_rect o_rect,
    input  logic          i_ready
);
    import scr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_NORM, S_SQRT, S_DIVINIT, S_DIV,
        S_UNIT, S_MUL, S_OFFS, S_PLACE, S_DEG, S_OUT
    } t_state;

    t_state                    r_state;
    t_seg                      r_seg;
    logic [SQ_W-1:0]           r_acc;
    logic [NORM_W-1:0]         r_n;
    logic [MAG_W-1:0]          r_mx;
    logic [MAG_W-1:0]          r_my;
    logic [REM_W-1:0]          r_rem;
    logic [ROOT_W-1:0]         r_root;
    logic [4:0]                r_cnt;
    logic [DIVN_W-1:0]         r_remx;
    logic [DIVN_W-1:0]         r_remy;
    logic [DIVN_W-1:0]         r_dsh;
    logic [QUO_W-1:0]          r_qx;
    logic [QUO_W-1:0]          r_qy;
    logic signed [UNIT_W-1:0]  r_ux;
    logic signed [UNIT_W-1:0]  r_uy;
    logic signed [PROD_W-1:0]  r_uwx;
    logic signed [PROD_W-1:0]  r_uwy;
    logic signed [PROD_W-1:0]  r_uex;
    logic signed [PROD_W-1:0]  r_uey;
    t_ro                       r_ro [8];
    t_rect                     r_res;
    t_rect                     r_out;
    logic                      r_out_valid;

    t_delta                    w_sq_op;
    logic signed [SQ_W-1:0]    w_sq;
    logic [DELTA_W-1:0]        w_magx;
    logic [DELTA_W-1:0]        w_magy;
    logic [REM_W+1:0]          n_rem_sh;
    logic [REM_W+1:0]          n_trial;
    logic [QUO_W-1:0]          w_qcx;
    logic [QUO_W-1:0]          w_qcy;
    logic signed [UNIT_W-1:0]  w_mul_a;
    logic signed [CFG_W:0]     w_mul_b;
    logic signed [UNIT_W+CFG_W:0] w_mul;
    logic signed [OFF_W-1:0]   w_uwx;
    logic signed [OFF_W-1:0]   w_uwy;
    logic signed [OFF_W-1:0]   w_uex;
    logic signed [OFF_W-1:0]   w_uey;
    logic [HW_W-1:0]           w_hw;
    logic signed [PLACE_W-1:0] w_h;
    logic signed [PLACE_W-1:0] w_px;
    logic signed [PLACE_W-1:0] w_py;
    logic                      w_load;

    assign o_pop_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rect      = r_out;
    assign w_load      = (r_state == S_OUT) && (!r_out_valid || i_ready);

    assign w_sq_op = (r_state == S_SQY) ? r_seg.dy : r_seg.dx;
    assign w_sq    = w_sq_op * w_sq_op;
    assign w_magx  = r_seg.dx[DELTA_W-1] ? DELTA_W'(-r_seg.dx) : DELTA_W'(r_seg.dx);
    assign w_magy  = r_seg.dy[DELTA_W-1] ? DELTA_W'(-r_seg.dy) : DELTA_W'(r_seg.dy);

    // one root digit per step
    assign n_rem_sh = {r_rem, r_n[NORM_W-1:NORM_W-2]};
    assign n_trial  = (REM_W+2)'({r_root, 2'b01});

    assign w_qcx = (r_qx > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE) : r_qx;
    assign w_qcy = (r_qy > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE) : r_qy;

    assign w_mul_a = r_cnt[0] ? r_uy : r_ux;
    assign w_mul_b = r_cnt[1] ? $signed({1'b0, i_cfg.ext_len})
                              : $signed({1'b0, i_cfg.corridor_width});
    assign w_mul   = w_mul_a * w_mul_b;

    assign w_uwx = OFF_W'(r_uwx);
    assign w_uwy = OFF_W'(r_uwy);
    assign w_uex = OFF_W'(r_uex);
    assign w_uey = OFF_W'(r_uey);

    // half side of the square for a zero-length segment
    assign w_hw = (HW_W'({i_cfg.corridor_width, {FRAC_BITS{1'b0}}})
                   + (HW_W'(1) << (HALF_SHIFT - 1))) >> HALF_SHIFT;
    assign w_h  = $signed(PLACE_W'(w_hw));
    assign w_px = PLACE_W'(r_seg.p1x);
    assign w_py = PLACE_W'(r_seg.p1y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_seg   <= i_pop_data;
                        r_state <= i_pop_data.degen ? S_DEG : S_SQX;
                    end
                end
                S_SQX: begin
                    r_acc   <= SQ_W'(w_sq);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_n     <= NORM_W'(r_acc + SQ_W'(w_sq));
                    r_mx    <= MAG_W'(w_magx);
                    r_my    <= MAG_W'(w_magy);
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // even left shift until one of the top two bits is set
                    if (r_n[NORM_W-1:NORM_W-8] == '0) begin
                        r_n  <= r_n << 8;
                        r_mx <= r_mx << 4;
                        r_my <= r_my << 4;
                    end else if (r_n[NORM_W-1:NORM_W-2] == '0) begin
                        r_n  <= r_n << 2;
                        r_mx <= r_mx << 1;
                        r_my <= r_my << 1;
                    end else begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (n_rem_sh >= n_trial) begin
                        r_rem  <= REM_W'(n_rem_sh - n_trial);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= REM_W'(n_rem_sh);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_n   <= r_n << 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                        r_state <= S_DIVINIT;
                    end
                end
                S_DIVINIT: begin
                    // numerator 2*|d|*2^(14+k/2) + L over 2L
                    r_remx  <= DIVN_W'({r_mx, {(UNIT_FRAC+1){1'b0}}}) + DIVN_W'(r_root);
                    r_remy  <= DIVN_W'({r_my, {(UNIT_FRAC+1){1'b0}}}) + DIVN_W'(r_root);
                    r_dsh   <= {r_root, 1'b0, {(QUO_W-1){1'b0}}};
                    r_qx    <= '0;
                    r_qy    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_remx >= r_dsh) begin
                        r_remx <= r_remx - r_dsh;
                        r_qx   <= {r_qx[QUO_W-2:0], 1'b1};
                    end else begin
                        r_qx   <= {r_qx[QUO_W-2:0], 1'b0};
                    end
                    if (r_remy >= r_dsh) begin
                        r_remy <= r_remy - r_dsh;
                        r_qy   <= {r_qy[QUO_W-2:0], 1'b1};
                    end else begin
                        r_qy   <= {r_qy[QUO_W-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(QUO_W - 1)) begin
                        r_state <= S_UNIT;
                    end
                end
                S_UNIT: begin
                    r_ux    <= r_seg.dx[DELTA_W-1] ? -$signed(w_qcx) : $signed(w_qcx);
                    r_uy    <= r_seg.dy[DELTA_W-1] ? -$signed(w_qcy) : $signed(w_qcy);
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    case (r_cnt[1:0])
                        2'd0:    r_uwx <= PROD_W'(w_mul);
                        2'd1:    r_uwy <= PROD_W'(w_mul);
                        2'd2:    r_uex <= PROD_W'(w_mul);
                        default: r_uey <= PROD_W'(w_mul);
                    endcase
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    r_ro[0] <= round_off(-w_uwy - w_uex);
                    r_ro[1] <= round_off(w_uwx - w_uey);
                    r_ro[2] <= round_off(w_uwy - w_uex);
                    r_ro[3] <= round_off(-w_uwx - w_uey);
                    r_ro[4] <= round_off(w_uwy + w_uex);
                    r_ro[5] <= round_off(-w_uwx + w_uey);
                    r_ro[6] <= round_off(-w_uwy + w_uex);
                    r_ro[7] <= round_off(w_uwx + w_uey);
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    r_res.c1x   <= place(r_seg.p1x, r_ro[0], i_cfg.map_width);
                    r_res.c1y   <= place(r_seg.p1y, r_ro[1], i_cfg.map_height);
                    r_res.c2x   <= place(r_seg.p1x, r_ro[2], i_cfg.map_width);
                    r_res.c2y   <= place(r_seg.p1y, r_ro[3], i_cfg.map_height);
                    r_res.c3x   <= place(r_seg.p2x, r_ro[4], i_cfg.map_width);
                    r_res.c3y   <= place(r_seg.p2y, r_ro[5], i_cfg.map_height);
                    r_res.c4x   <= place(r_seg.p2x, r_ro[6], i_cfg.map_width);
                    r_res.c4y   <= place(r_seg.p2y, r_ro[7], i_cfg.map_height);
                    r_res.degen <= 1'b0;
                    r_state     <= S_OUT;
                end
                S_DEG: begin
                    r_res.c1x   <= sat_coord(w_px - w_h);
                    r_res.c1y   <= sat_coord(w_py - w_h);
                    r_res.c2x   <= sat_coord(w_px + w_h);
                    r_res.c2y   <= sat_coord(w_py - w_h);
                    r_res.c3x   <= sat_coord(w_px + w_h);
                    r_res.c3y   <= sat_coord(w_py + w_h);
                    r_res.c4x   <= sat_coord(w_px - w_h);
                    r_res.c4y   <= sat_coord(w_py + w_h);
                    r_res.degen <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### src/segment_corridor_rectangle_unit.sv
// Corridor rectangle unit: one segment between consecutive path points -> four corners.
// Each segment goes through squaring, normalization of the squared length, the 31-step
// square root, the 16-step pair of dividers, unit vector, offsets and corner placement;
// a zero-length segment goes straight to a square. The single back-end sequencer takes
// no new segment until it is done with the last one; two segments can queue.
// Reset (synchronous, active low) clears point, queue and output valid, loads defaults.
module segment_corridor_rectangle_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scr_pt_if.sink            i_pt,
    scr_rect_if.source        o_rect,
    scr_cfg_if.sink           i_cfg
);
    import scr_pkg::*;
    `include "assert_macros.svh"

    t_cfg  r_cfg;
    logic  w_push;
    t_seg  w_push_seg;
    logic  w_push_ready;
    logic  w_pop_valid;
    t_seg  w_pop_seg;
    logic  w_pop_ready;
    t_rect w_rect;
    logic  w_in_acc;

    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_pt.valid && i_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.corridor_width <= 16'd1792;
            r_cfg.ext_len        <= 16'd2048;
            r_cfg.map_width      <= 15'd1;
            r_cfg.map_height     <= 15'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CORRIDOR_WIDTH: r_cfg.corridor_width <= i_cfg.data;
                REG_EXT_LEN:        r_cfg.ext_len        <= i_cfg.data;
                REG_MAP_WIDTH:      r_cfg.map_width      <= i_cfg.data[MAP_W-1:0];
                REG_MAP_HEIGHT:     r_cfg.map_height     <= i_cfg.data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    scr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_pt.valid),
        .o_ready      (i_pt.ready),
        .i_point_x    (i_pt.point_x),
        .i_point_y    (i_pt.point_y),
        .i_path_start (i_pt.path_start),
        .o_push       (w_push),
        .o_seg        (w_push_seg),
        .i_push_ready (w_push_ready)
    );

    scr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  (w_push_seg),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_seg),
        .i_pop_ready  (w_pop_ready)
    );

    scr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .i_pop_data  (w_pop_seg),
        .o_pop_ready (w_pop_ready),
        .o_valid     (o_rect.valid),
        .o_rect      (w_rect),
        .i_ready     (o_rect.ready)
    );

    assign o_rect.corner1_x  = w_rect.c1x;
    assign o_rect.corner1_y  = w_rect.c1y;
    assign o_rect.corner2_x  = w_rect.c2x;
    assign o_rect.corner2_y  = w_rect.c2y;
    assign o_rect.corner3_x  = w_rect.c3x;
    assign o_rect.corner3_y  = w_rect.c3y;
    assign o_rect.corner4_x  = w_rect.c4x;
    assign o_rect.corner4_y  = w_rect.c4y;
    assign o_rect.degenerate = w_rect.degen;

    // a path start word never becomes a segment
    `SCR_ASSERT_IMPL(a_start_no_push, i_clk, i_rst_n, w_in_acc && i_pt.path_start, !w_push)
    // a degenerate square shares x on its left side and y on its lower side
    `SCR_ASSERT_IMPL(a_square_shape, i_clk, i_rst_n, o_rect.valid && o_rect.degenerate,
        (o_rect.corner1_x == o_rect.corner4_x) && (o_rect.corner1_y == o_rect.corner2_y))
    // corner1 x and corner3 y of a clamped rectangle are never negative
    `SCR_ASSERT_IMPL(a_clamp_low, i_clk, i_rst_n, o_rect.valid && !o_rect.degenerate,
        !o_rect.corner1_x[COORD_WIDTH-1] && !o_rect.corner3_y[COORD_WIDTH-1])

endmodule
